[rtl/assert_macros.svh]
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// clocked check, off while reset is asserted
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// clocked check, also active during reset
`define ASSERT_CLK_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_CLK_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[rtl/rmsr_pkg.sv]
package rmsr_pkg;

  localparam int TIMER_BITS_DEF = 32;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_START_PWM  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REV_PERIOD = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAUSE      = 2'd3;

  localparam logic [7:0]  START_PWM_RST  = 8'd80;
  localparam logic [6:0]  RAMP_STEP_RST  = 7'd5;
  localparam logic [31:0] REV_PERIOD_RST = 32'd0;
  localparam logic [15:0] PAUSE_RST      = 16'd10;

  localparam logic [7:0] PWM_MAX   = 8'd255;
  localparam logic [6:0] SPEED_MAX = 7'd100;
  localparam logic [6:0] SPEED_MIN_RUN = 7'd2;

  // x / 100 == (x * 5243) >> 19 for every x up to 255 * 100
  localparam int RECIP_100   = 5243;
  localparam int RECIP_SHIFT = 19;
  localparam int SCALE_W     = 21;
  localparam logic [SCALE_W-1:0] SCALE_RST =
    SCALE_W'((255 - 80) * RECIP_100);

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_SPEED   = 2'd1,
    OP_DIR     = 2'd2,
    OP_TOGGLE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    PH_RAMP  = 2'd0,
    PH_HOLD  = 2'd1,
    PH_DOWN  = 2'd2,
    PH_PAUSE = 2'd3
  } phase_t;

endpackage

[rtl/rmsr_ifs.sv]
interface rmsr_in_if import rmsr_pkg::*;;
  logic       valid;
  logic       ready;
  op_t        operation;
  logic [6:0] speed_percent;
  logic       direction;
  logic       red_button;

  modport source (output valid, operation, speed_percent, direction, red_button,
                  input ready);
  modport sink   (input valid, operation, speed_percent, direction, red_button,
                  output ready);
endinterface

interface rmsr_out_if import rmsr_pkg::*;;
  logic       valid;
  logic       ready;
  logic [7:0] pwm_forward;
  logic [7:0] pwm_reverse;
  logic [6:0] speed_now;
  logic       direction_now;
  phase_t     phase;
  logic       halted;

  modport source (output valid, pwm_forward, pwm_reverse, speed_now, direction_now,
                  phase, halted, input ready);
  modport sink   (input valid, pwm_forward, pwm_reverse, speed_now, direction_now,
                  phase, halted, output ready);
endinterface

[rtl/rmsr_duty.sv]
module rmsr_duty import rmsr_pkg::*; (
  input  logic [6:0]         speed,
  input  logic [SCALE_W-1:0] scale,
  input  logic [7:0]         start_pwm,
  input  logic               dir,
  output logic [7:0]         duty_fwd,
  output logic [7:0]         duty_rev
);

  localparam int PROD_W = 7 + SCALE_W;

  logic [PROD_W-1:0] prod;
  logic [7:0]        span;
  logic [7:0]        duty;

  // scale holds (255 - start_pwm) * reciprocal of 100
  assign prod = PROD_W'(speed) * PROD_W'(scale);
  assign span = prod[RECIP_SHIFT +: 8];
  assign duty = start_pwm + span;

  always_comb begin
    duty_fwd = '0;
    duty_rev = '0;
    if (speed >= SPEED_MIN_RUN) begin
      if (dir) begin
        duty_rev = duty;
      end else begin
        duty_fwd = duty;
      end
    end
  end

endmodule

[rtl/reversing_motor_soft_ramp.sv]
// reversing motor soft ramp
// in_ch carries one item per handshake: a tick or a command (set speed,
// set direction, toggle direction) plus the stop button level. every item
// gives exactly one result item on out_ch with both pwm duties, the ramped
// speed, the running direction, the phase and the halted flag.
// an item is taken into the input register and is worked out on its way
// into the output register, which holds its result for out_ch until taken.
// throughput is one item per cycle while out_ch does not stall; the single
// pass of ramp, timer and duty logic between the two registers sets that
// figure.
// when out_ch stalls, the result is held and one more item is still taken
// into the input register; in_ch.ready drops only when both registers are full.
// the cfg port writes start_pwm, ramp_step, reverse_period_ticks and
// pause_ticks by index 0..3; writes are meant for an idle block and take
// effect on the next item.
// a synchronous active-low reset empties both registers, stops the motor
// at zero speed in the forward direction and restores the register defaults.
`include "assert_macros.svh"

module reversing_motor_soft_ramp import rmsr_pkg::*; #(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  rmsr_in_if.sink               in_ch,
  rmsr_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // configuration registers
  logic [7:0]         start_pwm_r;
  logic [6:0]         ramp_step_r;
  logic [31:0]        rev_period_r;
  logic [15:0]        pause_r;
  logic [SCALE_W-1:0] scale_r;   // (255 - start_pwm) * reciprocal, kept ready

  // input register
  logic       v1_r;
  op_t        op_r;
  logic [6:0] sp_r;
  logic       dr_r;
  logic       red_r;

  // motor state
  logic                  running_r, running_nxt;
  logic [6:0]            speed_r, speed_nxt;
  logic [6:0]            target_r, target_nxt;
  logic                  dir_r, dir_nxt;
  logic                  want_r, want_nxt;
  phase_t                phase_r, phase_nxt;
  logic [TIMER_BITS-1:0] wait_r, wait_nxt;
  logic [7:0]            duty_fwd_r, duty_fwd_nxt;
  logic [7:0]            duty_rev_r, duty_rev_nxt;

  // output register
  logic v2_r;
  logic halted_r, halted_nxt;

  logic                  adv2;
  logic                  proc;
  logic                  stopped;
  logic                  drive_en;
  logic [7:0]            up_sum;
  logic [6:0]            down_val;
  logic [TIMER_BITS-1:0] wait_dec;
  logic [7:0]            drv_fwd;
  logic [7:0]            drv_rev;

  // handshake: the output register frees up when empty or taken
  assign adv2        = !v2_r || out_ch.ready;
  assign proc        = v1_r && adv2;
  assign in_ch.ready = !v1_r || adv2;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_pwm_r  <= START_PWM_RST;
      ramp_step_r  <= RAMP_STEP_RST;
      rev_period_r <= REV_PERIOD_RST;
      pause_r      <= PAUSE_RST;
      scale_r      <= SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_START_PWM: begin
          start_pwm_r <= cfg_wdata[7:0];
          scale_r     <= SCALE_W'((PWM_MAX - cfg_wdata[7:0]) * SCALE_W'(RECIP_100));
        end
        CFG_RAMP_STEP:  ramp_step_r  <= cfg_wdata[6:0];
        CFG_REV_PERIOD: rev_period_r <= cfg_wdata[31:0];
        CFG_PAUSE:      pause_r      <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      v1_r <= 1'b1;
    end else if (proc) begin
      v1_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      op_r  <= in_ch.operation;
      sp_r  <= in_ch.speed_percent;
      dr_r  <= in_ch.direction;
      red_r <= in_ch.red_button;
    end
  end

  // duty for the speed being latched, on the running direction
  rmsr_duty u_duty (
    .speed     (speed_nxt),
    .scale     (scale_r),
    .start_pwm (start_pwm_r),
    .dir       (dir_r),
    .duty_fwd  (drv_fwd),
    .duty_rev  (drv_rev)
  );

  assign up_sum   = {1'b0, speed_r} + {1'b0, ramp_step_r};
  assign wait_dec = (wait_r != '0) ? wait_r - TIMER_BITS'(1) : wait_r;

  // clamped ramp down toward the target
  always_comb begin
    down_val = (speed_r > ramp_step_r) ? speed_r - ramp_step_r : 7'd0;
    if (down_val < target_r) begin
      down_val = target_r;
    end
  end

  // one item of work
  always_comb begin
    running_nxt = running_r;
    target_nxt  = target_r;
    want_nxt    = want_r;
    speed_nxt   = speed_r;
    dir_nxt     = dir_r;
    phase_nxt   = phase_r;
    wait_nxt    = wait_r;
    drive_en    = 1'b0;

    // commands touch the requested state first
    case (op_r)
      OP_SPEED: begin
        if (sp_r == 7'd0) begin
          running_nxt = 1'b0;
        end else begin
          running_nxt = 1'b1;
          target_nxt  = (sp_r > SPEED_MAX) ? SPEED_MAX : sp_r;
        end
      end
      OP_DIR:    want_nxt = dr_r;
      OP_TOGGLE: want_nxt = !want_r;
      default: ;
    endcase

    stopped = !running_nxt || red_r;

    if (op_r == OP_TICK) begin
      // a stop forces ramp down unless already at rest in down or pause
      if (stopped && (speed_r != 7'd0 || phase_r == PH_RAMP || phase_r == PH_HOLD)) begin
        phase_nxt = PH_DOWN;
      end
      if (running_nxt || speed_r != 7'd0) begin
        case (phase_nxt)
          PH_RAMP: begin
            if (speed_r == target_r) begin
              phase_nxt = PH_HOLD;
              wait_nxt  = TIMER_BITS'(rev_period_r);
            end else begin
              if (speed_r < target_r) begin
                speed_nxt = (up_sum > {1'b0, target_r}) ? target_r : up_sum[6:0];
              end else begin
                speed_nxt = down_val;
              end
              drive_en = 1'b1;
            end
          end
          PH_HOLD: begin
            wait_nxt = wait_dec;
            if (rev_period_r != '0 && wait_dec == '0) begin
              phase_nxt = PH_DOWN;
              want_nxt  = !want_r;
            end
          end
          PH_DOWN: begin
            if (speed_r <= ramp_step_r) begin
              speed_nxt = 7'd0;
              wait_nxt  = TIMER_BITS'(pause_r);
              phase_nxt = PH_PAUSE;
            end else begin
              speed_nxt = speed_r - ramp_step_r;
            end
            drive_en = 1'b1;
          end
          PH_PAUSE: begin
            wait_nxt = wait_dec;
            if (wait_dec == '0 && !stopped) begin
              dir_nxt   = want_r;
              phase_nxt = PH_RAMP;
            end
          end
          default: ;
        endcase
      end
    end else begin
      // commands re-evaluate the phase; at standstill and not stopped the new direction is taken at once
      if (stopped) begin
        phase_nxt = PH_DOWN;
      end else if (speed_r == 7'd0) begin
        phase_nxt = PH_RAMP;
        dir_nxt   = want_nxt;
      end else begin
        phase_nxt = (want_nxt == dir_r) ? PH_RAMP : PH_DOWN;
      end
    end

    halted_nxt = stopped;
  end

  // duties are relatched only on the steps of the ramp and down phases
  assign duty_fwd_nxt = drive_en ? drv_fwd : duty_fwd_r;
  assign duty_rev_nxt = drive_en ? drv_rev : duty_rev_r;

  // motor state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r  <= 1'b0;
      speed_r    <= '0;
      target_r   <= '0;
      dir_r      <= 1'b0;
      want_r     <= 1'b0;
      phase_r    <= PH_RAMP;
      wait_r     <= '0;
      duty_fwd_r <= '0;
      duty_rev_r <= '0;
    end else if (proc) begin
      running_r  <= running_nxt;
      speed_r    <= speed_nxt;
      target_r   <= target_nxt;
      dir_r      <= dir_nxt;
      want_r     <= want_nxt;
      phase_r    <= phase_nxt;
      wait_r     <= wait_nxt;
      duty_fwd_r <= duty_fwd_nxt;
      duty_rev_r <= duty_rev_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      halted_r <= halted_nxt;
    end
  end

  // state registers double as the result payload
  assign out_ch.valid         = v2_r;
  assign out_ch.pwm_forward   = duty_fwd_r;
  assign out_ch.pwm_reverse   = duty_rev_r;
  assign out_ch.speed_now     = speed_r;
  assign out_ch.direction_now = dir_r;
  assign out_ch.phase         = phase_r;
  assign out_ch.halted        = halted_r;

  // checks
  `ASSERT_CLK(a_one_side, clk, rst_n, duty_fwd_r == 8'd0 || duty_rev_r == 8'd0, "both driven")
  `ASSERT_CLK(a_speed_cap, clk, rst_n, speed_r <= SPEED_MAX, "speed above full scale")
  `ASSERT_CLK(a_pause_still, clk, rst_n, phase_r != PH_PAUSE || speed_r == 7'd0, "moving in pause")
  `ASSERT_CLK(a_idle, clk, rst_n, !proc |=> $stable({speed_r, phase_r, wait_r}), "state moved")
  `ASSERT_CLK(a_stall, clk, rst_n, !in_ch.ready |-> v1_r && v2_r && !out_ch.ready, "stall early")

endmodule
